// ----- hw/rtl/mdh_link_transform_macros.svh -----
// Assertion macros for the MDH link transform block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MDH_LINK_TRANSFORM_MACROS_SVH
`define MDH_LINK_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define MDH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdh check failed");
`define MDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdh check failed");
`else
`define MDH_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MDH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/mdh_pkg.sv -----
// Constants, types and the arctangent table for the MDH link transform.
// No dependencies.
`timescale 1ns / 1ps
package mdh_pkg;
   localparam int ZW = 34;      // Q2.30 datapath width with headroom
   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [17:0] Q14_ONE = 18'sd16384;

   typedef logic signed [ZW-1:0] q30_type;
   typedef logic signed [15:0] q14_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0: r = 32'h3243F6A8;
         5'd1: r = 32'h1DAC6705;
         5'd2: r = 32'h0FADBAFC;
         5'd3: r = 32'h07F56EA6;
         5'd4: r = 32'h03FEAB76;
         5'd5: r = 32'h01FFD55B;
         5'd6: r = 32'h00FFFAAA;
         5'd7: r = 32'h007FFF55;
         5'd8: r = 32'h003FFFEA;
         5'd9: r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // Negate on fold, round half up to Q1.14, clamp to +-1.0.
   function automatic q14_type to_q14(input q30_type v, input logic flip);
      q30_type n;
      q30_type t;
      logic signed [17:0] s;
      logic signed [17:0] c;
      n = flip ? -v : v;
      t = n + 34'sd32768;
      s = t[33:16];
      if (s > Q14_ONE) c = Q14_ONE;
      else if (s < -Q14_ONE) c = -Q14_ONE;
      else c = s;
      return c[15:0];
   endfunction
endpackage

// ----- hw/rtl/mdh_link_transform.sv -----
// From req word accepted to rsp_tvalid, a word passes the fold register, which the accepting
// edge loads, then one register per CORDIC iteration, the Q1.14 conversion register, the
// multiply register and the output register.
// Throughput: one word per cycle while rsp is not stalled; the unrolled CORDIC and the multiplier stage
// each hold one word per register. A stall on rsp freezes every stage.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`include "mdh_link_transform_macros.svh"
module mdh_link_transform #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] joint_angle, [31:16] link_twist, [63:32] link_length,
   // [95:64] link_offset
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] cos_angle, [31:16] sin_angle, [47:32] sin_angle_cos_twist,
   // [63:48] cos_angle_cos_twist, [79:64] sin_twist, [95:80] sin_angle_sin_twist,
   // [111:96] cos_angle_sin_twist, [127:112] cos_twist, [159:128] trans_x,
   // [191:160] trans_y, [223:192] trans_z
   output logic [223:0] rsp_tdata
);
   localparam int STEPS = (CORDIC_STEPS < mdh_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : mdh_pkg::ATAN_ENTRIES;
   localparam int CONV = STEPS + 1;
   localparam int MUL = STEPS + 2;

   // One global advance: every stage moves when the output slot frees up.
   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic v_ff [0:MUL];
   // index 0 = joint angle, 1 = link twist
   mdh_pkg::q30_type x_ff [0:STEPS][0:1];
   mdh_pkg::q30_type y_ff [0:STEPS][0:1];
   mdh_pkg::q30_type z_ff [0:STEPS][0:1];
   logic flip_ff [0:STEPS][0:1];
   logic signed [31:0] a_ff [0:MUL];
   logic signed [31:0] d_ff [0:CONV];

   // Fold angles into [-pi/2, pi/2]; record the sign flip.
   mdh_pkg::q30_type z_in [0:1];
   logic flip_in [0:1];
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         z_in[c] = {req_tdata[16*c+15], req_tdata[16*c +: 16], 17'b0};
         flip_in[c] = 1'b0;
         if (z_in[c] > mdh_pkg::HALF_PI_Q30) begin
            z_in[c] = z_in[c] - mdh_pkg::PI_Q30;
            flip_in[c] = 1'b1;
         end else if (z_in[c] < -mdh_pkg::HALF_PI_Q30) begin
            z_in[c] = z_in[c] + mdh_pkg::PI_Q30;
            flip_in[c] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req_tvalid;
      end
      if (advance) begin
         for (int c = 0; c < 2; c++) begin
            x_ff[0][c] <= mdh_pkg::INV_GAIN_Q30;
            y_ff[0][c] <= '0;
            z_ff[0][c] <= z_in[c];
            flip_ff[0][c] <= flip_in[c];
         end
         a_ff[0] <= req_tdata[63:32];
         d_ff[0] <= req_tdata[95:64];
      end
   end

   // One CORDIC iteration per register stage, both angles side by side.
   for (genvar k = 1; k <= STEPS; k++) begin : g_cordic
      localparam mdh_pkg::q30_type ATAN =
         {2'b0, mdh_pkg::atan_q30(5'(k - 1))};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (advance) begin
            for (int c = 0; c < 2; c++) begin
               if (z_ff[k-1][c] >= 0) begin
                  x_ff[k][c] <= x_ff[k-1][c] - (y_ff[k-1][c] >>> (k - 1));
                  y_ff[k][c] <= y_ff[k-1][c] + (x_ff[k-1][c] >>> (k - 1));
                  z_ff[k][c] <= z_ff[k-1][c] - ATAN;
               end else begin
                  x_ff[k][c] <= x_ff[k-1][c] + (y_ff[k-1][c] >>> (k - 1));
                  y_ff[k][c] <= y_ff[k-1][c] - (x_ff[k-1][c] >>> (k - 1));
                  z_ff[k][c] <= z_ff[k-1][c] + ATAN;
               end
               flip_ff[k][c] <= flip_ff[k-1][c];
            end
            a_ff[k] <= a_ff[k-1];
            d_ff[k] <= d_ff[k-1];
         end
      end
   end

   // Conversion to Q1.14, then the products.
   mdh_pkg::q14_type cq_ff, sq_ff, ca_ff, sa_ff;
   mdh_pkg::q14_type cq2_ff, sq2_ff, ca2_ff, sa2_ff;
   logic signed [31:0] p_sc_ff, p_cc_ff, p_ss_ff, p_cs_ff;
   logic signed [47:0] p_sd_ff, p_cd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[CONV] <= 1'b0;
         v_ff[MUL] <= 1'b0;
      end else if (advance) begin
         v_ff[CONV] <= v_ff[STEPS];
         v_ff[MUL] <= v_ff[CONV];
      end
      if (advance) begin
         cq_ff <= mdh_pkg::to_q14(x_ff[STEPS][0], flip_ff[STEPS][0]);
         sq_ff <= mdh_pkg::to_q14(y_ff[STEPS][0], flip_ff[STEPS][0]);
         ca_ff <= mdh_pkg::to_q14(x_ff[STEPS][1], flip_ff[STEPS][1]);
         sa_ff <= mdh_pkg::to_q14(y_ff[STEPS][1], flip_ff[STEPS][1]);
         a_ff[CONV] <= a_ff[STEPS];
         d_ff[CONV] <= d_ff[STEPS];
         cq2_ff <= cq_ff;
         sq2_ff <= sq_ff;
         ca2_ff <= ca_ff;
         sa2_ff <= sa_ff;
         p_sc_ff <= sq_ff * ca_ff;
         p_cc_ff <= cq_ff * ca_ff;
         p_ss_ff <= sq_ff * sa_ff;
         p_cs_ff <= cq_ff * sa_ff;
         p_sd_ff <= sa_ff * d_ff[CONV];
         p_cd_ff <= ca_ff * d_ff[CONV];
         a_ff[MUL] <= a_ff[CONV];
      end
   end

   // Round half up and saturate a Q1.14 x Q16.16 product.
   function automatic logic [31:0] round_sat(input logic signed [48:0] p);
      logic signed [48:0] t;
      logic signed [34:0] s;
      t = p + 49'sd8192;
      s = t[48:14];
      if (s > 35'sd2147483647) return 32'h7FFFFFFF;
      if (s < -35'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   function automatic logic [15:0] round_q14(input logic signed [31:0] p);
      logic signed [31:0] t;
      t = p + 32'sd8192;
      return t[29:14];
   endfunction

   logic out_valid_ff;
   logic [223:0] out_data_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= v_ff[MUL];
      end
      if (advance) begin
         out_data_ff <= {round_sat({p_cd_ff[47], p_cd_ff}),
                         round_sat(-{p_sd_ff[47], p_sd_ff}),
                         a_ff[MUL],
                         ca2_ff,
                         round_q14(p_cs_ff),
                         round_q14(p_ss_ff),
                         sa2_ff,
                         round_q14(p_cc_ff),
                         round_q14(p_sc_ff),
                         sq2_ff,
                         cq2_ff};
      end
   end

   // An accepted word shows up in the fold stage in the next cycle.
   `MDH_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, v_ff[0])
   // The cos_twist result stays within +-1.0 in Q1.14.
   `MDH_ASSERT_SAME(a_cos_range, clock, reset, rsp_tvalid, $signed(rsp_tdata[127:112]) <= 16'sd16384 && $signed(rsp_tdata[127:112]) >= -16'sd16384)
   // A stalled output stage keeps its word.
   `MDH_ASSERT_NEXT(a_hold_on_stall, clock, reset, out_valid_ff && !rsp_tready, out_valid_ff && $stable(out_data_ff))
endmodule
